// ===== rtl/core/read_quality_window_trimmer_macros.svh =====
// ----------------------------------------------------------------------------
// Read quality window trimmer assertion macros
// Shared concurrent assertion forms for the trimmer checkers.
// ----------------------------------------------------------------------------
`ifndef READ_QUALITY_WINDOW_TRIMMER_MACROS_SVH
`define READ_QUALITY_WINDOW_TRIMMER_MACROS_SVH

// same-cycle implication
`define RQWT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rqwt assertion failed");

// next-cycle implication
`define RQWT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rqwt assertion failed");

`endif

// ===== rtl/core/rqwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Read quality window trimmer package
// Field widths, register codes, character constants and shared types.
// ----------------------------------------------------------------------------
package rqwt_pkg;

    localparam int BASE_W     = 8;
    localparam int QCHAR_W    = 7;
    localparam int SCORE_W    = 7;
    localparam int SCORE_MAX  = 94;
    localparam int CFG_Q_W    = 7;
    localparam int CFG_L_W    = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int QT_W       = 23;
    localparam int UT_W       = 17;
    localparam int OUT_W      = 17;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 56;

    localparam logic [BASE_W-1:0]  BASE_UNKNOWN = 8'd78;
    localparam logic [QCHAR_W-1:0] QUAL_OFFSET  = 7'd33;

    localparam logic [CFG_L_W-1:0] RST_MAX_N_BASES   = 17'd0;
    localparam logic [CFG_Q_W-1:0] RST_MIN_AVG_QUAL  = 7'd25;
    localparam logic [CFG_Q_W-1:0] RST_MIN_WIN_QUAL  = 7'd25;
    localparam logic [CFG_L_W-1:0] RST_MIN_TRIM_LEN  = 17'd35;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MAX_N_BASES       = 2'd0,
        REG_MIN_AVERAGE_QUAL  = 2'd1,
        REG_MIN_WINDOW_QUAL   = 2'd2,
        REG_MIN_TRIMMED_LEN   = 2'd3
    } rqwt_reg_e_t;

    typedef struct packed {
        logic            cut_done;
        logic [QT_W-1:0] quality_total;
        logic [UT_W-1:0] unknown_total;
    } rqwt_totals_t;

endpackage

// ===== rtl/core/rqwt_cell.sv =====
// ----------------------------------------------------------------------------
// Delay line cell
// Holds one base score and its unknown flag; passes them on when shifted.
// ----------------------------------------------------------------------------
module rqwt_cell (
    input  logic                        aclk,
    input  logic                        shift_en,
    input  logic [rqwt_pkg::SCORE_W-1:0] in_q,
    input  logic                        in_n,
    output logic [rqwt_pkg::SCORE_W-1:0] out_q,
    output logic                        out_n
);
    import rqwt_pkg::*;

    logic [SCORE_W-1:0] q_reg;
    logic               n_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            q_reg <= in_q;
            n_reg <= in_n;
        end
    end

    assign out_q = q_reg;
    assign out_n = n_reg;

endmodule

// ===== rtl/core/rqwt_verdict.sv =====
// ----------------------------------------------------------------------------
// Read verdict pipeline
// Closes the totals of a finished read, applies the three filters and holds
// the verdict beat in an output register.
// ----------------------------------------------------------------------------
module rqwt_verdict #(
    parameter int WSUM_W = 9,
    parameter int WCNT_W = 3,
    parameter int POS_W  = 17
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rqwt_pkg::rqwt_totals_t        in_tot,
    input  logic [WSUM_W-1:0]             in_wsum,
    input  logic [WCNT_W-1:0]             in_wcnt,
    input  logic [POS_W-1:0]              in_len,
    input  logic [POS_W-1:0]              in_cutpos,
    input  logic [rqwt_pkg::CFG_L_W-1:0]  max_n_bases,
    input  logic [rqwt_pkg::CFG_Q_W-1:0]  min_avg_qual,
    input  logic [rqwt_pkg::CFG_L_W-1:0]  min_trim_len,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_keep,
    output logic [rqwt_pkg::OUT_W-1:0]    out_trimmed,
    output logic [rqwt_pkg::OUT_W-1:0]    out_len,
    output logic [rqwt_pkg::OUT_W-1:0]    out_unknown
);
    import rqwt_pkg::*;

    localparam int PROD_W = CFG_Q_W + POS_W;
    localparam int CQ_W   = (PROD_W > QT_W) ? PROD_W : QT_W;
    localparam int CL_W   = (POS_W > CFG_L_W) ? POS_W : CFG_L_W;

    // stage A: captured read summary
    logic               va_reg;
    rqwt_totals_t       tot_a_reg;
    logic [WSUM_W-1:0]  wsum_a_reg;
    logic [WCNT_W-1:0]  wcnt_a_reg;
    logic [POS_W-1:0]   len_a_reg;
    logic [POS_W-1:0]   cutpos_a_reg;

    // stage B: closed totals
    logic               vb_reg;
    logic [QT_W-1:0]    qt_b_reg;
    logic [UT_W-1:0]    ut_b_reg;
    logic [POS_W-1:0]   trim_b_reg;
    logic [POS_W-1:0]   len_b_reg;
    logic [PROD_W-1:0]  prod_b_reg;

    // output register
    logic               vo_reg;
    logic               keep_o_reg;
    logic [OUT_W-1:0]   trim_o_reg;
    logic [OUT_W-1:0]   len_o_reg;
    logic [OUT_W-1:0]   unk_o_reg;

    logic               adv_o;
    logic               adv_b;
    logic [QT_W:0]      qt_sum;
    logic [UT_W:0]      ut_sum;
    logic [QT_W-1:0]    qt_b_next;
    logic [UT_W-1:0]    ut_b_next;
    logic [POS_W-1:0]   trim_b_next;
    logic [PROD_W-1:0]  prod_b_next;
    logic               keep_o_next;

    assign adv_o    = !vo_reg || out_ready;
    assign adv_b    = !vb_reg || adv_o;
    assign in_ready = !va_reg || adv_b;

    always_comb begin
        qt_sum = {1'b0, tot_a_reg.quality_total} + (QT_W+1)'(wsum_a_reg);
        ut_sum = {1'b0, tot_a_reg.unknown_total} + (UT_W+1)'(wcnt_a_reg);
        if (tot_a_reg.cut_done) begin
            qt_b_next   = tot_a_reg.quality_total;
            ut_b_next   = tot_a_reg.unknown_total;
            trim_b_next = cutpos_a_reg;
        end else begin
            qt_b_next   = qt_sum[QT_W] ? '1 : qt_sum[QT_W-1:0];
            ut_b_next   = ut_sum[UT_W] ? '1 : ut_sum[UT_W-1:0];
            trim_b_next = len_a_reg;
        end
        prod_b_next = PROD_W'(min_avg_qual) * PROD_W'(len_a_reg);
    end

    always_comb begin
        keep_o_next = (len_b_reg != '0)
            && (ut_b_reg <= max_n_bases)
            && (CQ_W'(qt_b_reg) >= CQ_W'(prod_b_reg))
            && (CL_W'(trim_b_reg) >= CL_W'(min_trim_len));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                va_reg <= in_valid;
            end
            if (adv_b) begin
                vb_reg <= va_reg;
            end
            if (adv_o) begin
                vo_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            tot_a_reg    <= in_tot;
            wsum_a_reg   <= in_wsum;
            wcnt_a_reg   <= in_wcnt;
            len_a_reg    <= in_len;
            cutpos_a_reg <= in_cutpos;
        end
        if (adv_b) begin
            qt_b_reg   <= qt_b_next;
            ut_b_reg   <= ut_b_next;
            trim_b_reg <= trim_b_next;
            len_b_reg  <= len_a_reg;
            prod_b_reg <= prod_b_next;
        end
        if (adv_o) begin
            keep_o_reg <= keep_o_next;
            trim_o_reg <= OUT_W'(trim_b_reg);
            len_o_reg  <= OUT_W'(len_b_reg);
            unk_o_reg  <= OUT_W'(ut_b_reg);
        end
    end

    assign out_valid   = vo_reg;
    assign out_keep    = keep_o_reg;
    assign out_trimmed = trim_o_reg;
    assign out_len     = len_o_reg;
    assign out_unknown = unk_o_reg;

endmodule

// ===== rtl/core/read_quality_window_trimmer.sv =====
// ----------------------------------------------------------------------------
// Read quality window trimmer
// Sliding-window quality trimming of sequencer reads with a keep/discard
// verdict per read.
//
//   channel   dir   beat contents
//   s_        in    one base and its quality; tlast on the final base
//   m_        out   one verdict per read, issued after the tlast beat
//   cfg_      in    register write, index and data
//
// One base per cycle while s_tready is high, back to back across read boundaries.
// A verdict passes from its tlast beat through the summary register, the totals and
// product register, then filter compare into the output register.
// Reset is synchronous and clears control state and registers to defaults.
// s_tready drops only while all three verdict stages hold and m_tready is low.
// ----------------------------------------------------------------------------
module read_quality_window_trimmer #(
    parameter int WINDOW   = 5,
    parameter int MAX_READ = 65536
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // base_char [7:0], quality_char [14:8]
    input  logic [rqwt_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // trimmed_length [16:0], read_length [33:17], unknown_count [50:34]
    output logic [rqwt_pkg::M_TDATA_W-1:0]     m_tdata,
    // keep_read [0]
    output logic                               m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [rqwt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rqwt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import rqwt_pkg::*;

    localparam int POS_W  = $clog2(MAX_READ + 1);
    localparam int WSUM_W = $clog2(WINDOW * SCORE_MAX + 1);
    localparam int WCNT_W = $clog2(WINDOW + 1);
    localparam int THR_W  = $clog2((2**CFG_Q_W - 1) * WINDOW + 1);
    localparam int CMP_W  = (THR_W > WSUM_W) ? THR_W : WSUM_W;

    logic [CFG_L_W-1:0] max_n_reg;
    logic [CFG_Q_W-1:0] min_avg_reg;
    logic [CFG_Q_W-1:0] min_win_reg;
    logic [CFG_L_W-1:0] min_trim_reg;

    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [QT_W-1:0]    qt_reg,     qt_next;
    logic [UT_W-1:0]    ut_reg,     ut_next;
    logic [WSUM_W-1:0]  wsum_reg,   wsum_next;
    logic [WCNT_W-1:0]  wcnt_reg,   wcnt_next;
    logic               cut_reg,    cut_next;
    logic [POS_W-1:0]   cutpos_reg, cutpos_next;

    logic [POS_W-1:0]   step_pos;
    logic [QT_W-1:0]    step_qt;
    logic [UT_W-1:0]    step_ut;
    logic [WSUM_W-1:0]  step_wsum;
    logic [WCNT_W-1:0]  step_wcnt;
    logic               step_cut;
    logic [POS_W-1:0]   step_cutpos;

    logic [BASE_W-1:0]  base_char;
    logic [QCHAR_W-1:0] quality_char;
    logic [SCORE_W-1:0] score;
    logic               is_unknown;
    logic               beat;
    logic               in_range;
    logic               active;
    logic               full;
    logic               low_window;
    logic               retire;
    logic               cut_now;
    logic               push;
    logic [THR_W-1:0]   threshold;
    logic [QT_W:0]      qt_add;
    logic [UT_W:0]      ut_add;

    logic [SCORE_W-1:0] cell_q [WINDOW];
    logic               cell_n [WINDOW];

    rqwt_totals_t       sum_tot;
    logic               verdict_in_ready;
    logic               v_keep;
    logic [OUT_W-1:0]   v_trimmed;
    logic [OUT_W-1:0]   v_len;
    logic [OUT_W-1:0]   v_unknown;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_n_reg    <= RST_MAX_N_BASES;
            min_avg_reg  <= RST_MIN_AVG_QUAL;
            min_win_reg  <= RST_MIN_WIN_QUAL;
            min_trim_reg <= RST_MIN_TRIM_LEN;
        end else if (cfg_wr_en) begin
            case (rqwt_reg_e_t'(cfg_addr))
                REG_MAX_N_BASES:      max_n_reg    <= cfg_wdata[CFG_L_W-1:0];
                REG_MIN_AVERAGE_QUAL: min_avg_reg  <= cfg_wdata[CFG_Q_W-1:0];
                REG_MIN_WINDOW_QUAL:  min_win_reg  <= cfg_wdata[CFG_Q_W-1:0];
                REG_MIN_TRIMMED_LEN:  min_trim_reg <= cfg_wdata[CFG_L_W-1:0];
                default: ;
            endcase
        end
    end

    assign base_char    = s_tdata[BASE_W-1:0];
    assign quality_char = s_tdata[BASE_W +: QCHAR_W];
    assign score        = (quality_char >= QUAL_OFFSET) ? (quality_char - QUAL_OFFSET) : '0;
    assign is_unknown   = (base_char == BASE_UNKNOWN);

    assign s_tready   = verdict_in_ready;
    assign beat       = s_tvalid && s_tready;
    assign in_range   = (pos_reg < POS_W'(MAX_READ));
    assign active     = beat && in_range && !cut_reg;
    assign full       = (pos_reg >= POS_W'(WINDOW));
    assign threshold  = THR_W'(min_win_reg) * THR_W'(WINDOW);
    assign low_window = (CMP_W'(wsum_reg) < CMP_W'(threshold));
    assign retire     = active && full;
    assign cut_now    = retire && low_window;
    assign push       = active && !cut_now;

    // delay line
    generate
        for (genvar k = 0; k < WINDOW; k++) begin : g_cell
            if (k == 0) begin : g_head
                rqwt_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (push),
                    .in_q     (score),
                    .in_n     (is_unknown),
                    .out_q    (cell_q[k]),
                    .out_n    (cell_n[k])
                );
            end else begin : g_body
                rqwt_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (push),
                    .in_q     (cell_q[k-1]),
                    .in_n     (cell_n[k-1]),
                    .out_q    (cell_q[k]),
                    .out_n    (cell_n[k])
                );
            end
        end
    endgenerate

    // per-base step
    always_comb begin
        qt_add      = {1'b0, qt_reg} + (QT_W+1)'(cell_q[WINDOW-1]);
        ut_add      = {1'b0, ut_reg} + (UT_W+1)'(cell_n[WINDOW-1]);
        step_pos    = pos_reg;
        step_qt     = qt_reg;
        step_ut     = ut_reg;
        step_wsum   = wsum_reg;
        step_wcnt   = wcnt_reg;
        step_cut    = cut_reg;
        step_cutpos = cutpos_reg;
        if (retire) begin
            step_qt = qt_add[QT_W] ? '1 : qt_add[QT_W-1:0];
            step_ut = ut_add[UT_W] ? '1 : ut_add[UT_W-1:0];
        end
        if (cut_now) begin
            step_cut    = 1'b1;
            step_cutpos = pos_reg - POS_W'(WINDOW);
        end
        if (push) begin
            step_wsum = wsum_reg - (retire ? WSUM_W'(cell_q[WINDOW-1]) : '0)
                        + WSUM_W'(score);
            step_wcnt = wcnt_reg - (retire ? WCNT_W'(cell_n[WINDOW-1]) : '0)
                        + WCNT_W'(is_unknown);
        end
        if (beat && in_range) begin
            step_pos = pos_reg + POS_W'(1);
        end
    end

    // clear the read after its final beat
    always_comb begin
        if (beat && s_tlast) begin
            pos_next    = '0;
            qt_next     = '0;
            ut_next     = '0;
            wsum_next   = '0;
            wcnt_next   = '0;
            cut_next    = 1'b0;
            cutpos_next = '0;
        end else begin
            pos_next    = step_pos;
            qt_next     = step_qt;
            ut_next     = step_ut;
            wsum_next   = step_wsum;
            wcnt_next   = step_wcnt;
            cut_next    = step_cut;
            cutpos_next = step_cutpos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            qt_reg     <= '0;
            ut_reg     <= '0;
            wsum_reg   <= '0;
            wcnt_reg   <= '0;
            cut_reg    <= 1'b0;
            cutpos_reg <= '0;
        end else begin
            pos_reg    <= pos_next;
            qt_reg     <= qt_next;
            ut_reg     <= ut_next;
            wsum_reg   <= wsum_next;
            wcnt_reg   <= wcnt_next;
            cut_reg    <= cut_next;
            cutpos_reg <= cutpos_next;
        end
    end

    assign sum_tot.cut_done      = step_cut;
    assign sum_tot.quality_total = step_qt;
    assign sum_tot.unknown_total = step_ut;

    rqwt_verdict #(
        .WSUM_W (WSUM_W),
        .WCNT_W (WCNT_W),
        .POS_W  (POS_W)
    ) u_verdict (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (beat && s_tlast),
        .in_ready     (verdict_in_ready),
        .in_tot       (sum_tot),
        .in_wsum      (step_wsum),
        .in_wcnt      (step_wcnt),
        .in_len       (step_pos),
        .in_cutpos    (step_cutpos),
        .max_n_bases  (max_n_reg),
        .min_avg_qual (min_avg_reg),
        .min_trim_len (min_trim_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_keep     (v_keep),
        .out_trimmed  (v_trimmed),
        .out_len      (v_len),
        .out_unknown  (v_unknown)
    );

    assign m_tuser = v_keep;
    assign m_tdata = {{(M_TDATA_W - 3*OUT_W){1'b0}}, v_unknown, v_len, v_trimmed};

endmodule

// ===== rtl/core/rqwt_checker.sv =====
// ----------------------------------------------------------------------------
// Read quality window trimmer checker
// Port-level assertions on the verdict stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "read_quality_window_trimmer_macros.svh"

module rqwt_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [rqwt_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                               m_tuser
);
    import rqwt_pkg::*;

    logic [OUT_W-1:0] trimmed_len;
    logic [OUT_W-1:0] read_len;
    logic             out_stall;

    assign trimmed_len = m_tdata[OUT_W-1:0];
    assign read_len    = m_tdata[OUT_W +: OUT_W];
    assign out_stall   = m_tvalid && !m_tready;

    // hold a stalled verdict beat
    `RQWT_ASSERT_NXT(a_stall_hold, aclk, aresetn, out_stall, m_tvalid && $stable({m_tuser, m_tdata}))
    // leave reset with no verdict pending and the input open
    `RQWT_ASSERT_IMP(a_reset_empty, aclk, aresetn, $rose(aresetn), !m_tvalid && s_tready)
    // trimmed length never exceeds read length
    `RQWT_ASSERT_IMP(a_trim_bound, aclk, aresetn, m_tvalid, trimmed_len <= read_len)
    // input stalls only behind a full verdict pipeline
    `RQWT_ASSERT_IMP(a_ready_backpressure, aclk, aresetn, !s_tready, out_stall)

endmodule

bind read_quality_window_trimmer rqwt_checker u_rqwt_checker (.*);
